@@ src/linear_scan_register_allocator_macros.svh @@
`ifndef LINEAR_SCAN_REGISTER_ALLOCATOR_MACROS_SVH
`define LINEAR_SCAN_REGISTER_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked on clk and disabled while rst_n is low.
`define LSRA_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk and disabled while rst_n is low.
`define LSRA_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/lsra_pkg.sv @@
package lsra_pkg;

    localparam int NUM_PREGS = 16;
    localparam int PHYS_W    = $clog2(NUM_PREGS);
    localparam int CNT_W     = $clog2(NUM_PREGS + 1);
    localparam int VREG_W    = 16;
    localparam int POS_W     = 20;

    typedef enum logic [1:0] {
        OUT_FREE  = 2'd0,
        OUT_STEAL = 2'd1,
        OUT_SPILL = 2'd2
    } outcome_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPACT,
        ST_DECIDE,
        ST_SCAN
    } state_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_EXPIRE,
        CELL_SHIFT,
        CELL_WRITE,
        CELL_KILL
    } cell_op_t;

    typedef struct packed {
        logic [VREG_W-1:0] vreg;
        logic [POS_W-1:0]  end_pos;
        logic [PHYS_W-1:0] phys;
    } entry_t;

    typedef struct packed {
        cell_op_t          op;
        logic              clear;
        logic [POS_W-1:0]  start_pos;
        entry_t            wr;
    } cell_cmd_t;

endpackage

@@ src/lsra_cell.sv @@
module lsra_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  lsra_pkg::cell_cmd_t cmd,
    input  logic              sel,
    input  logic              hole_in,
    input  logic              right_valid,
    input  lsra_pkg::entry_t  right_ent,
    output logic              hole_out,
    output logic              valid,
    output lsra_pkg::entry_t  ent,
    output logic              expired
);
    import lsra_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    entry_t ent_reg;
    entry_t ent_next;
    logic   stale;

    assign stale    = ent_reg.end_pos < cmd.start_pos;
    assign expired  = valid_reg && stale && (cmd.op == CELL_EXPIRE);
    // A cell moves its right neighbor in when it or any cell below it is empty.
    assign hole_out = hole_in | ~valid_reg;
    assign valid    = valid_reg;
    assign ent      = ent_reg;

    always_comb
    begin
        valid_next = valid_reg;
        ent_next   = ent_reg;
        case (cmd.op)
            CELL_EXPIRE:
            begin
                valid_next = valid_reg && !cmd.clear && !stale;
            end
            CELL_SHIFT:
            begin
                if (hole_out)
                begin
                    valid_next = right_valid;
                    ent_next   = right_ent;
                end
            end
            CELL_WRITE:
            begin
                if (sel)
                begin
                    valid_next = 1'b1;
                    ent_next   = cmd.wr;
                end
            end
            CELL_KILL:
            begin
                if (sel)
                begin
                    valid_next = 1'b0;
                end
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

endmodule

@@ src/linear_scan_register_allocator.sv @@
// Linear-scan register allocator. Pulse start with one live interval while busy is low; the
// result comes back on done for exactly one cycle and must be taken then, since the receiver
// cannot stall. The active list lives in a chain of sixteen cells. Stale entries expire in
// the accepting cycle. The chain then closes emptied cells ahead of live entries, one cell per
// cycle, and finds the list packed before the decision state. The result is registered out of
// the decision state, and busy drops with it, so the next item can be taken while done shows.
// When no register is free and the list is not empty, the cells are scanned one per cycle for
// the greatest end. A steal then kills the victim, compacts the chain again and writes the
// new item in a second decision. Writes on cfg_wr_en set max_regs at once; the user is to
// write it only while idle so it takes effect for the next item; the block does not enforce it.
`include "linear_scan_register_allocator_macros.svh"

module linear_scan_register_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          new_function,
    input  logic [lsra_pkg::VREG_W-1:0]   virtual_reg,
    input  logic [lsra_pkg::POS_W-1:0]    interval_start,
    input  logic [lsra_pkg::POS_W-1:0]    interval_end,
    input  logic                          cfg_wr_en,
    input  logic [lsra_pkg::CNT_W-1:0]    cfg_wr_data,
    output logic                          done,
    output logic [1:0]                    outcome,
    output logic [lsra_pkg::PHYS_W-1:0]   phys_reg,
    output logic                          evicted_valid,
    output logic [lsra_pkg::VREG_W-1:0]   evicted_vreg,
    output logic [lsra_pkg::CNT_W-1:0]    regs_used
);
    import lsra_pkg::*;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      max_regs_reg;
    logic [NUM_PREGS-1:0]  reg_free_reg, reg_free_next;
    logic [CNT_W-1:0]      used_reg, used_next;
    logic [VREG_W-1:0]     vreg_reg, vreg_next;
    logic [POS_W-1:0]      end_reg, end_next;
    logic                  pending_reg, pending_next;
    logic [PHYS_W-1:0]     steal_phys_reg, steal_phys_next;
    logic [VREG_W-1:0]     steal_vreg_reg, steal_vreg_next;
    logic [CNT_W-1:0]      n_reg, n_next;
    logic [PHYS_W-1:0]     scan_idx_reg, scan_idx_next;
    logic [POS_W-1:0]      best_end_reg, best_end_next;
    logic [PHYS_W-1:0]     best_idx_reg, best_idx_next;
    logic [PHYS_W-1:0]     best_phys_reg, best_phys_next;
    logic [VREG_W-1:0]     best_vreg_reg, best_vreg_next;

    logic                  done_reg, done_next;
    outcome_t              outcome_reg, outcome_next;
    logic [PHYS_W-1:0]     phys_out_reg, phys_out_next;
    logic                  ev_valid_reg, ev_valid_next;
    logic [VREG_W-1:0]     ev_vreg_reg, ev_vreg_next;
    logic [CNT_W-1:0]      used_out_reg, used_out_next;

    cell_cmd_t             cmd;
    logic [NUM_PREGS-1:0]  sel;
    logic [NUM_PREGS:0]    hole;
    logic [NUM_PREGS-1:0]  vld;
    logic [NUM_PREGS-1:0]  expired;
    logic [NUM_PREGS-1:0]  r_vld;
    entry_t                cell_ent [NUM_PREGS];
    entry_t                r_ent    [NUM_PREGS];

    logic [NUM_PREGS-1:0]  freed;
    logic                  hole_any;
    logic [CNT_W-1:0]      n_cnt;
    logic [CNT_W-1:0]      limit;
    logic                  free_found;
    logic [PHYS_W-1:0]     free_idx;
    logic [CNT_W-1:0]      free_plus1;

    entry_t                cur;
    logic                  upd;
    logic                  scan_last;
    logic                  steal;
    logic [POS_W-1:0]      fin_end;
    logic [PHYS_W-1:0]     fin_idx;
    logic [PHYS_W-1:0]     fin_phys;
    logic [VREG_W-1:0]     fin_vreg;

    assign hole[0] = 1'b0;

    genvar g;
    for (g = 0; g < NUM_PREGS; g++)
    begin : g_cell
        if (g == NUM_PREGS - 1)
        begin : g_tail
            assign r_vld[g] = 1'b0;
            assign r_ent[g] = '0;
        end
        else
        begin : g_body
            assign r_vld[g] = vld[g+1];
            assign r_ent[g] = cell_ent[g+1];
        end

        lsra_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .sel         (sel[g]),
            .hole_in     (hole[g]),
            .right_valid (r_vld[g]),
            .right_ent   (r_ent[g]),
            .hole_out    (hole[g+1]),
            .valid       (vld[g]),
            .ent         (cell_ent[g]),
            .expired     (expired[g])
        );
    end

    always_comb
    begin
        freed    = '0;
        hole_any = 1'b0;
        for (int i = 0; i < NUM_PREGS; i++)
        begin
            if (expired[i])
            begin
                freed[cell_ent[i].phys] = 1'b1;
            end
            // A live cell with an empty one below it means the list is not packed yet.
            if (vld[i] && hole[i])
            begin
                hole_any = 1'b1;
            end
        end
    end

    assign n_cnt = CNT_W'($countones(vld));
    assign limit = (max_regs_reg > CNT_W'(NUM_PREGS)) ? CNT_W'(NUM_PREGS) : max_regs_reg;

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_PREGS - 1; i >= 0; i--)
        begin
            if (reg_free_reg[i] && (CNT_W'(i) < limit))
            begin
                free_found = 1'b1;
                free_idx   = PHYS_W'(i);
            end
        end
    end

    assign free_plus1 = CNT_W'(free_idx) + CNT_W'(1);

    // Scan keeps the first entry with the greatest end.
    assign cur       = cell_ent[scan_idx_reg];
    assign upd       = (scan_idx_reg == '0) || (cur.end_pos > best_end_reg);
    assign scan_last = (CNT_W'(scan_idx_reg) + CNT_W'(1)) == n_reg;
    assign fin_end   = upd ? cur.end_pos  : best_end_reg;
    assign fin_idx   = upd ? scan_idx_reg : best_idx_reg;
    assign fin_phys  = upd ? cur.phys     : best_phys_reg;
    assign fin_vreg  = upd ? cur.vreg     : best_vreg_reg;
    assign steal     = fin_end > end_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_COMPACT;
                end
            end
            ST_COMPACT:
            begin
                if (!hole_any)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (!pending_reg && !free_found && (n_cnt != '0))
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = steal ? ST_COMPACT : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.op          = CELL_HOLD;
        cmd.clear       = new_function;
        cmd.start_pos   = interval_start;
        cmd.wr.vreg     = vreg_reg;
        cmd.wr.end_pos  = end_reg;
        cmd.wr.phys     = free_idx;
        sel             = '0;
        reg_free_next   = reg_free_reg;
        used_next       = used_reg;
        vreg_next       = vreg_reg;
        end_next        = end_reg;
        pending_next    = pending_reg;
        steal_phys_next = steal_phys_reg;
        steal_vreg_next = steal_vreg_reg;
        n_next          = n_reg;
        scan_idx_next   = scan_idx_reg;
        best_end_next   = best_end_reg;
        best_idx_next   = best_idx_reg;
        best_phys_next  = best_phys_reg;
        best_vreg_next  = best_vreg_reg;
        done_next       = 1'b0;
        outcome_next    = outcome_reg;
        phys_out_next   = phys_out_reg;
        ev_valid_next   = ev_valid_reg;
        ev_vreg_next    = ev_vreg_reg;
        used_out_next   = used_out_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.op    = CELL_EXPIRE;
                    vreg_next = virtual_reg;
                    end_next  = interval_end;
                    if (new_function)
                    begin
                        reg_free_next = '1;
                        used_next     = '0;
                    end
                    else
                    begin
                        reg_free_next = reg_free_reg | freed;
                    end
                end
            end
            ST_COMPACT:
            begin
                if (hole_any)
                begin
                    cmd.op = CELL_SHIFT;
                end
            end
            ST_DECIDE:
            begin
                n_next = n_cnt;
                for (int i = 0; i < NUM_PREGS; i++)
                begin
                    sel[i] = (CNT_W'(i) == n_cnt);
                end
                if (pending_reg)
                begin
                    cmd.op        = CELL_WRITE;
                    cmd.wr.phys   = steal_phys_reg;
                    pending_next  = 1'b0;
                    done_next     = 1'b1;
                    outcome_next  = OUT_STEAL;
                    phys_out_next = steal_phys_reg;
                    ev_valid_next = 1'b1;
                    ev_vreg_next  = steal_vreg_reg;
                    used_out_next = used_reg;
                end
                else if (free_found)
                begin
                    cmd.op                  = CELL_WRITE;
                    reg_free_next[free_idx] = 1'b0;
                    if (free_plus1 > used_reg)
                    begin
                        used_next = free_plus1;
                    end
                    done_next     = 1'b1;
                    outcome_next  = OUT_FREE;
                    phys_out_next = free_idx;
                    ev_valid_next = 1'b0;
                    ev_vreg_next  = '0;
                    used_out_next = (free_plus1 > used_reg) ? free_plus1 : used_reg;
                end
                else if (n_cnt == '0)
                begin
                    done_next     = 1'b1;
                    outcome_next  = OUT_SPILL;
                    phys_out_next = '0;
                    ev_valid_next = 1'b0;
                    ev_vreg_next  = '0;
                    used_out_next = used_reg;
                end
                else
                begin
                    scan_idx_next = '0;
                end
            end
            ST_SCAN:
            begin
                best_end_next  = fin_end;
                best_idx_next  = fin_idx;
                best_phys_next = fin_phys;
                best_vreg_next = fin_vreg;
                scan_idx_next  = scan_idx_reg + PHYS_W'(1);
                if (scan_last)
                begin
                    if (steal)
                    begin
                        // The victim leaves the chain; its register goes to the new item.
                        cmd.op = CELL_KILL;
                        for (int i = 0; i < NUM_PREGS; i++)
                        begin
                            sel[i] = (PHYS_W'(i) == fin_idx);
                        end
                        pending_next    = 1'b1;
                        steal_phys_next = fin_phys;
                        steal_vreg_next = fin_vreg;
                    end
                    else
                    begin
                        done_next     = 1'b1;
                        outcome_next  = OUT_SPILL;
                        phys_out_next = '0;
                        ev_valid_next = 1'b0;
                        ev_vreg_next  = '0;
                        used_out_next = used_reg;
                    end
                end
            end
            default:
            begin
                cmd.op = CELL_HOLD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            max_regs_reg <= CNT_W'(NUM_PREGS);
            reg_free_reg <= '1;
            used_reg     <= '0;
            pending_reg  <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            reg_free_reg <= reg_free_next;
            used_reg     <= used_next;
            pending_reg  <= pending_next;
            done_reg     <= done_next;
            if (cfg_wr_en)
            begin
                max_regs_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        vreg_reg       <= vreg_next;
        end_reg        <= end_next;
        steal_phys_reg <= steal_phys_next;
        steal_vreg_reg <= steal_vreg_next;
        n_reg          <= n_next;
        scan_idx_reg   <= scan_idx_next;
        best_end_reg   <= best_end_next;
        best_idx_reg   <= best_idx_next;
        best_phys_reg  <= best_phys_next;
        best_vreg_reg  <= best_vreg_next;
        outcome_reg    <= outcome_next;
        phys_out_reg   <= phys_out_next;
        ev_valid_reg   <= ev_valid_next;
        ev_vreg_reg    <= ev_vreg_next;
        used_out_reg   <= used_out_next;
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign outcome       = outcome_reg;
    assign phys_reg      = phys_out_reg;
    assign evicted_valid = ev_valid_reg;
    assign evicted_vreg  = ev_vreg_reg;
    assign regs_used     = used_out_reg;

    `LSRA_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
    `LSRA_ASSERT_IMP(a_done_idle, done, !busy, "result delivered while still busy")
    `LSRA_ASSERT_IMP(a_decide_packed, state_reg == ST_DECIDE, !hole_any, "active list not packed")
    `LSRA_ASSERT_IMP(a_scan_nonempty, state_reg == ST_SCAN, n_reg != '0, "scan of empty list")
    `LSRA_ASSERT_IMP(a_evict_steal, done && evicted_valid, outcome == OUT_STEAL, "eviction without steal")

endmodule

@@ tb/linear_scan_register_allocator_checker.sv @@
`timescale 1ns / 1ps

module linear_scan_register_allocator_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          new_function,
    input  logic [lsra_pkg::VREG_W-1:0]   virtual_reg,
    input  logic [lsra_pkg::POS_W-1:0]    interval_start,
    input  logic [lsra_pkg::POS_W-1:0]    interval_end,
    input  logic                          cfg_wr_en,
    input  logic [lsra_pkg::CNT_W-1:0]    cfg_wr_data,
    input  logic                          done,
    input  logic [1:0]                    outcome,
    input  logic [lsra_pkg::PHYS_W-1:0]   phys_reg,
    input  logic                          evicted_valid,
    input  logic [lsra_pkg::VREG_W-1:0]   evicted_vreg,
    input  logic [lsra_pkg::CNT_W-1:0]    regs_used,
    output int                            fail_count,
    output int                            pending,
    output int                            steal_count,
    output int                            spill_count
);
    import lsra_pkg::*;

    typedef struct packed {
        outcome_t          outcome;
        logic [PHYS_W-1:0] phys;
        logic              ev_valid;
        logic [VREG_W-1:0] ev_vreg;
        logic [CNT_W-1:0]  used;
    } alloc_result_t;

    // Predicted allocator state.
    logic [CNT_W-1:0]     reg_count;
    logic [NUM_PREGS-1:0] free_map;
    logic [CNT_W-1:0]     high_water;
    entry_t               live_list[$];

    alloc_result_t        expected_allocs[$];
    alloc_result_t        want;
    int                   result_index = 0;

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("[%0t] MISMATCH on result %0d: %s", $time, result_index, msg);
    endtask

    function automatic alloc_result_t allocate_interval(
        input logic              nf,
        input logic [VREG_W-1:0] vreg,
        input logic [POS_W-1:0]  first_pos,
        input logic [POS_W-1:0]  last_pos
    );
        alloc_result_t r;
        entry_t        ent;
        int            limit;
        int            pick;
        int            best;
        int            i;

        r.outcome  = OUT_SPILL;
        r.phys     = '0;
        r.ev_valid = 1'b0;
        r.ev_vreg  = '0;
        if (nf) begin
            live_list.delete();
            free_map   = '1;
            high_water = '0;
        end

        // Drop every live interval that ended before this one starts.
        i = 0;
        while (i < live_list.size()) begin
            if (live_list[i].end_pos < first_pos) begin
                free_map[live_list[i].phys] = 1'b1;
                live_list.delete(i);
            end
            else begin
                i++;
            end
        end

        limit = (reg_count < NUM_PREGS) ? int'(reg_count) : NUM_PREGS;
        pick  = -1;
        for (i = 0; i < limit; i++) begin
            if (free_map[i] && pick < 0)
                pick = i;
        end

        ent.vreg    = vreg;
        ent.end_pos = last_pos;
        if (pick >= 0) begin
            free_map[pick] = 1'b0;
            ent.phys = PHYS_W'(pick);
            if (live_list.size() < NUM_PREGS)
                live_list.insert(live_list.size(), ent);
            if (pick + 1 > int'(high_water))
                high_water = CNT_W'(pick + 1);
            r.outcome = OUT_FREE;
            r.phys    = PHYS_W'(pick);
        end
        else begin
            // The first entry holding the greatest end is the steal candidate.
            best = 0;
            for (i = 1; i < live_list.size(); i++) begin
                if (live_list[i].end_pos > live_list[best].end_pos)
                    best = i;
            end
            if (live_list.size() > 0 && live_list[best].end_pos > last_pos) begin
                r.outcome  = OUT_STEAL;
                r.phys     = live_list[best].phys;
                r.ev_valid = 1'b1;
                r.ev_vreg  = live_list[best].vreg;
                ent.phys   = live_list[best].phys;
                live_list.delete(best);
                live_list.insert(live_list.size(), ent);
            end
        end
        r.used = high_water;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            reg_count  = CNT_W'(NUM_PREGS);
            free_map   = '1;
            high_water = '0;
            live_list.delete();
            expected_allocs.delete();
            pending <= 0;
        end
        else begin
            if (cfg_wr_en)
                reg_count = cfg_wr_data;
            if (done) begin
                if (expected_allocs.size() == 0) begin
                    report_mismatch("result strobe with no item outstanding");
                end
                else begin
                    want = expected_allocs.pop_front();
                    if (outcome !== want.outcome)
                        report_mismatch($sformatf("outcome got %0d expected %0d",
                                                  outcome, want.outcome));
                    if (phys_reg !== want.phys)
                        report_mismatch($sformatf("phys_reg got %0d expected %0d",
                                                  phys_reg, want.phys));
                    if (evicted_valid !== want.ev_valid)
                        report_mismatch($sformatf("evicted_valid got %b expected %b",
                                                  evicted_valid, want.ev_valid));
                    if (evicted_vreg !== want.ev_vreg)
                        report_mismatch($sformatf("evicted_vreg got %h expected %h",
                                                  evicted_vreg, want.ev_vreg));
                    if (regs_used !== want.used)
                        report_mismatch($sformatf("regs_used got %0d expected %0d",
                                                  regs_used, want.used));
                end
                result_index++;
            end
            if (start && !busy) begin
                want = allocate_interval(new_function, virtual_reg, interval_start,
                                         interval_end);
                if (want.outcome == OUT_STEAL)
                    steal_count++;
                if (want.outcome == OUT_SPILL)
                    spill_count++;
                expected_allocs.insert(expected_allocs.size(), want);
            end
            pending <= expected_allocs.size();
        end
    end

endmodule

@@ tb/linear_scan_register_allocator_tb.sv @@
`timescale 1ns / 1ps

module linear_scan_register_allocator_tb;
    import lsra_pkg::*;

    localparam int QUIET_LIMIT  = 4000;
    localparam int RANDOM_ITEMS = 550;
    localparam int DRAIN_CYCLES = 60;
    localparam int POS_MAX      = 20'hFFFFF;

    logic                clk            = 1'b0;
    logic                rst_n          = 1'b0;
    logic                start          = 1'b0;
    logic                new_function   = 1'b0;
    logic [VREG_W-1:0]   virtual_reg    = '0;
    logic [POS_W-1:0]    interval_start = '0;
    logic [POS_W-1:0]    interval_end   = '0;
    logic                cfg_wr_en      = 1'b0;
    logic [CNT_W-1:0]    cfg_wr_data    = '0;

    logic                busy;
    logic                done;
    logic [1:0]          outcome;
    logic [PHYS_W-1:0]   phys_reg;
    logic                evicted_valid;
    logic [VREG_W-1:0]   evicted_vreg;
    logic [CNT_W-1:0]    regs_used;

    int fail_count;
    int pending;
    int steal_count;
    int spill_count;
    int items_sent   = 0;
    int cfg_writes   = 0;
    int quiet_cycles = 0;

    linear_scan_register_allocator dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .new_function   (new_function),
        .virtual_reg    (virtual_reg),
        .interval_start (interval_start),
        .interval_end   (interval_end),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .done           (done),
        .outcome        (outcome),
        .phys_reg       (phys_reg),
        .evicted_valid  (evicted_valid),
        .evicted_vreg   (evicted_vreg),
        .regs_used      (regs_used)
    );

    linear_scan_register_allocator_checker check_unit (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .new_function   (new_function),
        .virtual_reg    (virtual_reg),
        .interval_start (interval_start),
        .interval_end   (interval_end),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .done           (done),
        .outcome        (outcome),
        .phys_reg       (phys_reg),
        .evicted_valid  (evicted_valid),
        .evicted_vreg   (evicted_vreg),
        .regs_used      (regs_used),
        .fail_count     (fail_count),
        .pending        (pending),
        .steal_count    (steal_count),
        .spill_count    (spill_count)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Ends the run if neither an item nor a result moves for too long.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Timeout: no item or result moved for %0d cycles", QUIET_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Mostly back to back, sometimes a few cycles, now and then a long pause.
    function automatic int gap_cycles();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60)
            return 0;
        if (sel < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Register counts lean small to force steals and spills.
    function automatic int pick_reg_count();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return 0;
        if (sel == 1)
            return $urandom_range(17, 31);
        if (sel == 2)
            return NUM_PREGS;
        return $urandom_range(1, 8);
    endfunction

    task automatic wait_idle();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0 || busy);
    endtask

    task automatic write_max_regs(input int value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= CNT_W'(value);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cfg_writes++;
    endtask

    task automatic send_interval(input logic nf, input int vreg, input int first_pos,
                                 input int last_pos, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start          <= 1'b1;
        new_function   <= nf;
        virtual_reg    <= VREG_W'(vreg);
        interval_start <= POS_W'(first_pos);
        interval_end   <= POS_W'(last_pos);
        do
            @(posedge clk);
        while (busy);
        items_sent++;
    endtask

    initial
    begin
        int target;
        int fn_len;
        int cur;
        int len;
        int sel;
        int k;
        int gap;
        bit no_gaps;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Field extremes, an end below its start and a start out of order.
        write_max_regs(NUM_PREGS);
        send_interval(1'b1, 16'h0000, 0, 0, 0);
        send_interval(1'b0, 16'hFFFF, 0, POS_MAX, 0);
        send_interval(1'b0, 16'h0001, 5, 3, 1);
        send_interval(1'b0, 16'h0002, 2, 9, 0);
        send_interval(1'b0, 16'h0003, POS_MAX, POS_MAX, 0);

        // Two registers: fill, steal, spill, and a tie on the end that spills.
        write_max_regs(2);
        send_interval(1'b1, 10, 0, 100, 0);
        send_interval(1'b0, 11, 1, 50, 0);
        send_interval(1'b0, 12, 2, 70, 2);
        send_interval(1'b0, 13, 3, 200, 0);
        send_interval(1'b0, 14, 3, 70, 0);

        // No registers at all: stealing from held entries, then an empty list.
        write_max_regs(0);
        send_interval(1'b0, 15, 4, 60, 0);
        send_interval(1'b1, 16, 5, 5, 0);

        // A count above the register file behaves as the full file.
        write_max_regs(31);
        send_interval(1'b1, 20, 0, 1000, 0);
        send_interval(1'b0, 21, 0, 1000, 0);

        // Shrink the count while four registers are still held.
        write_max_regs(4);
        send_interval(1'b1, 30, 0, 900, 0);
        send_interval(1'b0, 31, 1, 800, 0);
        send_interval(1'b0, 32, 2, 700, 0);
        send_interval(1'b0, 33, 3, 600, 0);
        write_max_regs(1);
        send_interval(1'b0, 34, 4, 100, 0);
        send_interval(1'b0, 35, 5, 5000, 0);
        send_interval(1'b0, 36, 6000, 6000, 0);

        // Random functions: ordered intervals with random content plus some noise.
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target)
        begin
            if ($urandom_range(0, 9) < 3)
                write_max_regs(pick_reg_count());
            fn_len  = $urandom_range(4, 40);
            cur     = ($urandom_range(0, 3) == 0) ? $urandom_range(20'hF0000, POS_MAX)
                                                  : $urandom_range(0, 5000);
            no_gaps = ($urandom_range(0, 3) == 0);
            for (k = 0; k < fn_len && items_sent < target; k++)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 2)
                    write_max_regs(pick_reg_count());
                else if (sel < 3)
                    wait_idle();
                gap = no_gaps ? 0 : gap_cycles();
                if (sel >= 3 && sel < 11)
                begin
                    send_interval(1'($urandom_range(0, 1)), $urandom_range(0, 16'hFFFF),
                                  $urandom_range(0, POS_MAX), $urandom_range(0, POS_MAX), gap);
                end
                else
                begin
                    cur = cur + (($urandom_range(0, 9) == 0) ? $urandom_range(7, 60)
                                                             : $urandom_range(0, 6));
                    if (cur > POS_MAX)
                        cur = cur & POS_MAX;
                    len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8)
                                                      : $urandom_range(10, 150);
                    send_interval(k == 0, $urandom_range(0, 16'hFFFF), cur,
                                  (cur + len > POS_MAX) ? POS_MAX : cur + len, gap);
                end
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d intervals over %0d register-count writes", items_sent,
                 cfg_writes);
        $display("Predicted %0d steals and %0d spills", steal_count, spill_count);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
